// File: design/uvs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvs_pkg
// Shared types and constants of the UV sphere vertex generator.
// ----------------------------------------------------------------------------
package uvs_pkg;

	localparam int SEG_W           = 11;
	localparam int COORD_FRAC_BITS = 15;
	localparam int COORD_W         = COORD_FRAC_BITS + 1;
	localparam int TEX_W           = 17;
	localparam int IDX_W           = 21;
	localparam int CFG_IDX_W       = 8;

	localparam logic [TEX_W-1:0] TEX_MAX = '1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_X_SEGMENTS = 8'd0,
		CFG_Y_SEGMENTS = 8'd1
	} cfg_reg_t;

	typedef struct packed {
		logic [SEG_W-1:0] column;
		logic [SEG_W-1:0] row;
	} in_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] pos_x;
		logic signed [COORD_W-1:0] pos_y;
		logic signed [COORD_W-1:0] pos_z;
		logic [TEX_W-1:0]          tex_u;
		logic [TEX_W-1:0]          tex_v;
		logic [IDX_W-1:0]          tri_index0;
		logic [IDX_W-1:0]          tri_index1;
		logic [IDX_W-1:0]          tri_index2;
		logic [IDX_W-1:0]          tri_index3;
		logic [IDX_W-1:0]          tri_index4;
		logic [IDX_W-1:0]          tri_index5;
		logic                      has_quad;
	} out_t;

	// pipelined restoring divider: DIV_BITS quotient bits per stage
	localparam int DIV_STAGES = 11;
	localparam int DIV_BITS   = 4;
	localparam int DIV_NUM_W  = DIV_STAGES * DIV_BITS;

	// angles: 32-bit turn phase, magnitudes Q30 in 31 bits
	localparam int PHASE_W = 32;
	localparam int MAG_W   = 31;
	localparam logic [MAG_W-1:0]   Q30_ONE = 31'h4000_0000;
	localparam logic [PHASE_W-1:0] PI_Q30  = 32'hC90F_DAA2;

	// Horner steps; x/d done as (x*M) >> S, exact for x < 2^30
	localparam int HORNER_STEPS = 6;
	localparam int unsigned COS_SHIFT [HORNER_STEPS] = '{38, 37, 36, 35, 34, 31};
	localparam int unsigned SIN_SHIFT [HORNER_STEPS] = '{38, 37, 37, 36, 35, 33};
	localparam logic [MAG_W-1:0] COS_MAGIC [HORNER_STEPS] = '{
		31'(((64'd1 << 38) + 64'd131) / 64'd132),
		31'(((64'd1 << 37) + 64'd89)  / 64'd90),
		31'(((64'd1 << 36) + 64'd55)  / 64'd56),
		31'(((64'd1 << 35) + 64'd29)  / 64'd30),
		31'(((64'd1 << 34) + 64'd11)  / 64'd12),
		31'(((64'd1 << 31) + 64'd1)   / 64'd2)
	};
	localparam logic [MAG_W-1:0] SIN_MAGIC [HORNER_STEPS] = '{
		31'(((64'd1 << 38) + 64'd155) / 64'd156),
		31'(((64'd1 << 37) + 64'd109) / 64'd110),
		31'(((64'd1 << 37) + 64'd71)  / 64'd72),
		31'(((64'd1 << 36) + 64'd41)  / 64'd42),
		31'(((64'd1 << 35) + 64'd19)  / 64'd20),
		31'(((64'd1 << 33) + 64'd5)   / 64'd6)
	};

	// sine/cosine pipeline depth: front stages, stages per Horner step, back stages
	localparam int SC_LAT = 3 + 3 * HORNER_STEPS + 2;

endpackage

// File: design/uvs_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvs_div
// Pipelined restoring divider, numerator by segment count, one quotient
// nibble per stage. Numerator bits shift out the top as quotient bits
// shift in at the bottom.
// ----------------------------------------------------------------------------
module uvs_div (
	input  logic                          clk,
	input  logic                          en,
	input  logic [uvs_pkg::DIV_NUM_W-1:0] num,
	input  logic [uvs_pkg::SEG_W-1:0]     den,
	output logic [uvs_pkg::DIV_NUM_W-1:0] quo
);
	import uvs_pkg::*;

	logic [DIV_NUM_W-1:0] nq_s  [DIV_STAGES];
	logic [SEG_W-1:0]     rem_s [DIV_STAGES-1];
	logic [SEG_W-1:0]     den_s [DIV_STAGES-1];

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		logic [DIV_NUM_W-1:0] nq_in, nq_nx;
		logic [SEG_W-1:0]     rem_in, rem_nx, den_in;
		logic [SEG_W:0]       w;

		if (k == 0) begin : g_first
			assign nq_in  = num;
			assign rem_in = '0;
			assign den_in = den;
		end else begin : g_next
			assign nq_in  = nq_s[k-1];
			assign rem_in = rem_s[k-1];
			assign den_in = den_s[k-1];
		end

		always_comb begin
			nq_nx  = nq_in;
			rem_nx = rem_in;
			w      = '0;
			for (int b = 0; b < DIV_BITS; b++) begin
				w = {rem_nx, nq_nx[DIV_NUM_W-1]};
				if (w >= {1'b0, den_in}) begin
					rem_nx = SEG_W'(w - {1'b0, den_in});
					nq_nx  = {nq_nx[DIV_NUM_W-2:0], 1'b1};
				end else begin
					rem_nx = w[SEG_W-1:0];
					nq_nx  = {nq_nx[DIV_NUM_W-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				nq_s[k] <= nq_nx;
			end
		end

		if (k < DIV_STAGES - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k] <= rem_nx;
					den_s[k] <= den_in;
				end
			end
		end
	end

	assign quo = nq_s[DIV_STAGES-1];

endmodule

// File: design/uvs_sincos.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvs_sincos
// Pipelined sine and cosine of a 32-bit turn phase: octant fold, radian
// scale, six-step Horner polynomials, quadrant mapping to magnitude + sign.
// ----------------------------------------------------------------------------
module uvs_sincos (
	input  logic                        clk,
	input  logic                        en,
	input  logic [uvs_pkg::PHASE_W-1:0] phase,
	output logic [uvs_pkg::MAG_W-1:0]   sin_mag,
	output logic                        sin_neg,
	output logic [uvs_pkg::MAG_W-1:0]   cos_mag,
	output logic                        cos_neg
);
	import uvs_pkg::*;

	typedef enum logic [1:0] {
		QUAD_FIRST,
		QUAD_SECOND,
		QUAD_THIRD,
		QUAD_FOURTH
	} quad_t;

	typedef struct packed {
		logic [29:0] th;
		logic [29:0] s2;
		quad_t       quad;
		logic        swap;
	} sc_ctl_t;

	// front: fold, scale to radians, square
	logic [29:0] t_s1;
	quad_t       quad_s1, quad_s2;
	logic        swap_s1, swap_s2;
	logic [29:0] th_s2;
	sc_ctl_t     ctl_s3;
	logic [61:0] th_prod, sq_prod;
	logic        fold;

	assign fold    = phase[29:0] > 30'h2000_0000;
	assign th_prod = 62'(t_s1) * 62'(PI_Q30);
	assign sq_prod = 62'(th_s2) * 62'(th_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			quad_s1     <= quad_t'(phase[31:30]);
			swap_s1     <= fold;
			t_s1        <= fold ? 30'(Q30_ONE - {1'b0, phase[29:0]}) : phase[29:0];
			quad_s2     <= quad_s1;
			swap_s2     <= swap_s1;
			th_s2       <= th_prod[60:31];
			ctl_s3.th   <= th_s2;
			ctl_s3.s2   <= sq_prod[59:30];
			ctl_s3.quad <= quad_s2;
			ctl_s3.swap <= swap_s2;
		end
	end

	// Horner: multiply, reciprocal multiply, shift and subtract
	sc_ctl_t          ctl_sa [HORNER_STEPS];
	sc_ctl_t          ctl_sb [HORNER_STEPS];
	sc_ctl_t          ctl_sc [HORNER_STEPS];
	logic [29:0]      xc_sa  [HORNER_STEPS];
	logic [29:0]      xs_sa  [HORNER_STEPS];
	logic [60:0]      yc_sb  [HORNER_STEPS];
	logic [60:0]      ys_sb  [HORNER_STEPS];
	logic [MAG_W-1:0] rc_sc  [HORNER_STEPS];
	logic [MAG_W-1:0] rs_sc  [HORNER_STEPS];

	for (genvar k = 0; k < HORNER_STEPS; k++) begin : g_horner
		sc_ctl_t          ctl_in;
		logic [MAG_W-1:0] rc_in, rs_in;
		logic [60:0]      pc, ps, mc, ms;

		if (k == 0) begin : g_first
			assign ctl_in = ctl_s3;
			assign rc_in  = Q30_ONE;
			assign rs_in  = Q30_ONE;
		end else begin : g_next
			assign ctl_in = ctl_sc[k-1];
			assign rc_in  = rc_sc[k-1];
			assign rs_in  = rs_sc[k-1];
		end

		assign pc = 61'(ctl_in.s2) * 61'(rc_in);
		assign ps = 61'(ctl_in.s2) * 61'(rs_in);
		assign mc = 61'(xc_sa[k]) * 61'(COS_MAGIC[k]);
		assign ms = 61'(xs_sa[k]) * 61'(SIN_MAGIC[k]);

		always_ff @(posedge clk) begin
			if (en) begin
				ctl_sa[k] <= ctl_in;
				xc_sa[k]  <= pc[59:30];
				xs_sa[k]  <= ps[59:30];
				ctl_sb[k] <= ctl_sa[k];
				yc_sb[k]  <= mc;
				ys_sb[k]  <= ms;
				ctl_sc[k] <= ctl_sb[k];
				rc_sc[k]  <= Q30_ONE - MAG_W'(yc_sb[k] >> COS_SHIFT[k]);
				rs_sc[k]  <= Q30_ONE - MAG_W'(ys_sb[k] >> SIN_SHIFT[k]);
			end
		end
	end

	// back: sine = th * poly, then unfold
	logic [MAG_W-1:0] s0_s4, c0_s4, sa, ca;
	quad_t            quad_s4;
	logic             swap_s4;
	logic [60:0]      sin_prod;

	assign sin_prod = 61'(ctl_sc[HORNER_STEPS-1].th) * 61'(rs_sc[HORNER_STEPS-1]);

	always_ff @(posedge clk) begin
		if (en) begin
			s0_s4   <= sin_prod[60:30];
			c0_s4   <= rc_sc[HORNER_STEPS-1];
			quad_s4 <= ctl_sc[HORNER_STEPS-1].quad;
			swap_s4 <= ctl_sc[HORNER_STEPS-1].swap;
		end
	end

	assign sa = swap_s4 ? c0_s4 : s0_s4;
	assign ca = swap_s4 ? s0_s4 : c0_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			case (quad_s4)
				QUAD_FIRST: begin
					sin_mag <= sa; sin_neg <= 1'b0; cos_mag <= ca; cos_neg <= 1'b0;
				end
				QUAD_SECOND: begin
					sin_mag <= ca; sin_neg <= 1'b0; cos_mag <= sa; cos_neg <= 1'b1;
				end
				QUAD_THIRD: begin
					sin_mag <= sa; sin_neg <= 1'b1; cos_mag <= ca; cos_neg <= 1'b1;
				end
				default: begin
					sin_mag <= ca; sin_neg <= 1'b1; cos_mag <= sa; cos_neg <= 1'b0;
				end
			endcase
		end
	end

endmodule

// File: design/uv_sphere_vertex_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uv_sphere_vertex_generator
// Position, texture coordinates and quad indices of one UV sphere grid point.
// ----------------------------------------------------------------------------
// Usage:
//   item    : one grid point (column, row) per beat, valid/ready.
//   result  : one vertex per item, valid/ready, in order of arrival.
//   cfg     : x_segments (index 0) and y_segments (index 1); other indices
//             are dropped. Always ready. Write only with the pipe empty.
// Throughput is one item per cycle while results are taken. An item passes
// through 37 register stages: one entry stage, 11 divider stages (four
// quotient bits each), 23 stages of sine/cosine (six Horner steps of three
// stages), a product stage and the output register.
// The pipe advances as a whole: when the output register holds a beat that
// is not taken, item_ready drops and every stage holds; bubbles in the pipe
// do not close up during a stall.
// Reset empties the pipe and loads 32 columns and 16 rows.
// ----------------------------------------------------------------------------
module uv_sphere_vertex_generator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_ready,
	input  uvs_pkg::in_t                  item,
	output logic                          result_valid,
	input  logic                          result_ready,
	output uvs_pkg::out_t                 result,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [uvs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [uvs_pkg::SEG_W-1:0]     cfg_data
);
	import uvs_pkg::*;

	localparam int S_DIV_OUT  = 1 + DIV_STAGES;
	localparam int S_SC_OUT   = S_DIV_OUT + SC_LAT;
	localparam int PIPE_DEPTH = S_SC_OUT + 2;
	localparam int IDX_LEN    = PIPE_DEPTH - 2;
	localparam int TEX_LEN    = PIPE_DEPTH - 1 - S_DIV_OUT;
	localparam int COORD_RW   = COORD_FRAC_BITS + 2;
	localparam int XY_SH      = 60 - COORD_FRAC_BITS;
	localparam int Z_SH       = 30 - COORD_FRAC_BITS;
	localparam logic [60:0] XY_HALF = 61'(1) << (XY_SH - 1);
	localparam logic [31:0] Z_HALF  = 32'(1) << (Z_SH - 1);
	localparam logic [COORD_RW-1:0] COORD_TOP = COORD_RW'(1) << COORD_FRAC_BITS;

	typedef struct packed {
		logic [IDX_W-1:0] a;
		logic [IDX_W-1:0] b;
		logic             has_quad;
	} idx_t;

	typedef struct packed {
		logic [TEX_W-1:0] u;
		logic [TEX_W-1:0] v;
	} tex_t;

	function automatic logic [COORD_W-1:0] sat_coord(input logic [COORD_RW-1:0] r,
	                                                 input logic neg);
		logic [COORD_RW-1:0] m;
		if (neg) begin
			m = (r > COORD_TOP) ? COORD_TOP : r;
			return COORD_W'(COORD_RW'(0) - m);
		end
		m = (r > COORD_TOP - 1'b1) ? COORD_TOP - 1'b1 : r;
		return COORD_W'(m);
	endfunction

	// configuration
	logic [SEG_W-1:0] x_seg_q, y_seg_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_seg_q <= SEG_W'(32);
			y_seg_q <= SEG_W'(16);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_X_SEGMENTS: x_seg_q <= cfg_data;
				CFG_Y_SEGMENTS: y_seg_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipe control
	logic en;
	logic vld_q [PIPE_DEPTH];

	assign en           = !vld_q[PIPE_DEPTH-1] || result_ready;
	assign item_ready   = en;
	assign result_valid = vld_q[PIPE_DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int n = 0; n < PIPE_DEPTH; n++) vld_q[n] <= 1'b0;
		end else if (en) begin
			vld_q[0] <= item_valid;
			for (int n = 1; n < PIPE_DEPTH; n++) vld_q[n] <= vld_q[n-1];
		end
	end

	// entry stage: zero counts act as one, numerators rounded to nearest
	logic [SEG_W-1:0]     xe, ye;
	logic [SEG_W-1:0]     i_s1, j_s1, xe_s1, ye_s1;
	logic [DIV_NUM_W-1:0] nyaw_s1, npitch_s1, ntu_s1, ntv_s1;

	assign xe = (x_seg_q == '0) ? SEG_W'(1) : x_seg_q;
	assign ye = (y_seg_q == '0) ? SEG_W'(1) : y_seg_q;

	always_ff @(posedge clk) begin
		if (en) begin
			i_s1      <= item.column;
			j_s1      <= item.row;
			xe_s1     <= xe;
			ye_s1     <= ye;
			nyaw_s1   <= (DIV_NUM_W'(item.column) << 32) + DIV_NUM_W'(xe >> 1);
			npitch_s1 <= (DIV_NUM_W'(item.row) << 31) + DIV_NUM_W'(ye >> 1);
			ntu_s1    <= (DIV_NUM_W'(item.column) << 16) + DIV_NUM_W'(xe >> 1);
			ntv_s1    <= (DIV_NUM_W'(item.row) << 16) + DIV_NUM_W'(ye >> 1);
		end
	end

	// quad indices, carried to the output
	idx_t        idx_nx;
	idx_t        idx_dly_q [IDX_LEN];
	logic [23:0] base_a;

	always_comb begin
		base_a          = 24'(i_s1) * 24'({1'b0, ye_s1} + 12'd1) + 24'(j_s1);
		idx_nx.a        = base_a[IDX_W-1:0];
		idx_nx.b        = IDX_W'(base_a + 24'(ye_s1) + 24'd1);
		idx_nx.has_quad = (i_s1 < xe_s1) && (j_s1 < ye_s1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			idx_dly_q[0] <= idx_nx;
			for (int n = 1; n < IDX_LEN; n++) idx_dly_q[n] <= idx_dly_q[n-1];
		end
	end

	// dividers
	logic [DIV_NUM_W-1:0] q_yaw, q_pitch, q_tu, q_tv;

	uvs_div u_div_yaw   (.clk(clk), .en(en), .num(nyaw_s1),   .den(xe_s1), .quo(q_yaw));
	uvs_div u_div_pitch (.clk(clk), .en(en), .num(npitch_s1), .den(ye_s1), .quo(q_pitch));
	uvs_div u_div_tu    (.clk(clk), .en(en), .num(ntu_s1),    .den(xe_s1), .quo(q_tu));
	uvs_div u_div_tv    (.clk(clk), .en(en), .num(ntv_s1),    .den(ye_s1), .quo(q_tv));

	// texture coordinates, saturated, carried to the output
	tex_t tex_nx;
	tex_t tex_dly_q [TEX_LEN];

	assign tex_nx.u = (q_tu > DIV_NUM_W'(TEX_MAX)) ? TEX_MAX : q_tu[TEX_W-1:0];
	assign tex_nx.v = (q_tv > DIV_NUM_W'(TEX_MAX)) ? TEX_MAX : q_tv[TEX_W-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			tex_dly_q[0] <= tex_nx;
			for (int n = 1; n < TEX_LEN; n++) tex_dly_q[n] <= tex_dly_q[n-1];
		end
	end

	// angles and trig
	logic [PHASE_W-1:0] yaw, pitch;
	logic [MAG_W-1:0]   ys, yc, ps, pc;
	logic               ysn, ycn, psn, pcn;

	assign yaw   = q_yaw[PHASE_W-1:0];
	assign pitch = PHASE_W'(0) - PHASE_W'(32'h4000_0000) - q_pitch[PHASE_W-1:0];

	uvs_sincos u_sc_yaw (
		.clk(clk), .en(en), .phase(yaw),
		.sin_mag(ys), .sin_neg(ysn), .cos_mag(yc), .cos_neg(ycn)
	);

	uvs_sincos u_sc_pitch (
		.clk(clk), .en(en), .phase(pitch),
		.sin_mag(ps), .sin_neg(psn), .cos_mag(pc), .cos_neg(pcn)
	);

	// products
	logic [61:0]      px_full, py_full;
	logic [60:0]      mx_q, my_q;
	logic [MAG_W-1:0] mz_q;
	logic             nx_q, ny_q, nz_q;

	assign px_full = 62'(pc) * 62'(yc);
	assign py_full = 62'(pc) * 62'(ys);

	always_ff @(posedge clk) begin
		if (en) begin
			mx_q <= px_full[60:0];
			my_q <= py_full[60:0];
			mz_q <= ps;
			nx_q <= pcn ^ ycn;
			ny_q <= pcn ^ ysn;
			nz_q <= psn;
		end
	end

	// output register
	out_t res_nx, result_q;
	idx_t idx_end;
	tex_t tex_end;

	assign idx_end = idx_dly_q[IDX_LEN-1];
	assign tex_end = tex_dly_q[TEX_LEN-1];

	always_comb begin
		res_nx.pos_x = sat_coord(COORD_RW'((mx_q + XY_HALF) >> XY_SH), nx_q);
		res_nx.pos_y = sat_coord(COORD_RW'((my_q + XY_HALF) >> XY_SH), ny_q);
		res_nx.pos_z = sat_coord(COORD_RW'((32'(mz_q) + Z_HALF) >> Z_SH), nz_q);
		res_nx.tex_u = tex_end.u;
		res_nx.tex_v = tex_end.v;
		res_nx.has_quad = idx_end.has_quad;
		if (idx_end.has_quad) begin
			res_nx.tri_index0 = idx_end.a;
			res_nx.tri_index1 = idx_end.b;
			res_nx.tri_index2 = idx_end.a + 1'b1;
			res_nx.tri_index3 = idx_end.a + 1'b1;
			res_nx.tri_index4 = idx_end.b;
			res_nx.tri_index5 = idx_end.b + 1'b1;
		end else begin
			res_nx.tri_index0 = '0;
			res_nx.tri_index1 = '0;
			res_nx.tri_index2 = '0;
			res_nx.tri_index3 = '0;
			res_nx.tri_index4 = '0;
			res_nx.tri_index5 = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result_q <= res_nx;
		end
	end

	assign result = result_q;

	// checks
	a_quad_shape: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.has_quad |->
			result.tri_index3 == result.tri_index0 + 1'b1 &&
			result.tri_index5 == result.tri_index1 + 1'b1)
		else $error("quad indices out of shape");

	a_no_quad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.has_quad |->
			result.tri_index0 == '0 && result.tri_index1 == '0 &&
			result.tri_index5 == '0)
		else $error("indices set without a quad");

	a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> vld_q[0] == $past(vld_q[0]))
		else $error("pipe moved during a stall");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the UV sphere vertex generator. Grid points are streamed
// through the block under several segment settings, extremes included. Each
// vertex is checked field by field against an in-order queue: two vertices
// from a table, the rest from a fixed-point sine/cosine predictor. Both
// channels idle in random bursts; one long output hold-off fills the pipe.
// ----------------------------------------------------------------------------
module tb_top;
	import uvs_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 8'd5;
	localparam int PIPE_LAT    = 37;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 300;
	localparam logic [63:0] ONE_Q30 = 64'h4000_0000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	in_t  item = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	out_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [SEG_W-1:0] cfg_data = '0;

	out_t vertex_q[$];
	logic [SEG_W-1:0] cols_sh, rows_sh;
	int errors = 0;
	int cycles = 0;
	bit quiet = 0;
	bit hold_req = 0;

	uv_sphere_vertex_generator dut (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// ---------------- predictor ----------------
	function automatic void sin_cos(input logic [31:0] ph, output logic [63:0] sm,
			output bit sneg, output logic [63:0] cm, output bit cneg);
		logic [63:0] t, th, sq, rc, rs, s0, c0, tmp;
		bit swap;
		int cd[6];
		int sd[6];
		cd = '{132, 90, 56, 30, 12, 2};
		sd = '{156, 110, 72, 42, 20, 6};
		t = {34'd0, ph[29:0]};
		swap = 0;
		if (t > 64'h2000_0000) begin
			t = ONE_Q30 - t;
			swap = 1;
		end
		th = (t * 64'hC90F_DAA2) >> 31;
		sq = (th * th) >> 30;
		rc = ONE_Q30;
		rs = ONE_Q30;
		for (int k = 0; k < 6; k++) begin
			rc = ONE_Q30 - ((sq * rc) >> 30) / cd[k];
			rs = ONE_Q30 - ((sq * rs) >> 30) / sd[k];
		end
		s0 = (th * rs) >> 30;
		c0 = rc;
		if (swap) begin
			tmp = s0; s0 = c0; c0 = tmp;
		end
		case (ph[31:30])
			2'd0: begin sm = s0; sneg = 0; cm = c0; cneg = 0; end
			2'd1: begin sm = c0; sneg = 0; cm = s0; cneg = 1; end
			2'd2: begin sm = s0; sneg = 1; cm = c0; cneg = 1; end
			default: begin sm = c0; sneg = 1; cm = s0; cneg = 0; end
		endcase
	endfunction

	function automatic logic [COORD_W-1:0] coord(input logic [63:0] mag, input int sh,
			input bit neg);
		logic [63:0] r;
		r = (mag + (64'd1 << (sh - 1))) >> sh;
		if (neg) begin
			if (r > (64'd1 << COORD_FRAC_BITS)) r = 64'd1 << COORD_FRAC_BITS;
			r = 64'd0 - r;
		end else if (r > (64'd1 << COORD_FRAC_BITS) - 1) begin
			r = (64'd1 << COORD_FRAC_BITS) - 1;
		end
		return r[COORD_W-1:0];
	endfunction

	function automatic logic [TEX_W-1:0] tex(input logic [63:0] n, input logic [63:0] d);
		logic [63:0] r;
		r = ((n << 16) + (d >> 1)) / d;
		return (r > 64'd131071) ? TEX_MAX : r[TEX_W-1:0];
	endfunction

	function automatic out_t vertex_of(input in_t p);
		out_t v;
		logic [63:0] i, j, nx, ny, jp, a, b, ys, yc, ps, pc;
		logic [31:0] yaw, pitch;
		bit ysn, ycn, psn, pcn;
		i = p.column;
		j = p.row;
		nx = cols_sh ? cols_sh : 1;
		ny = rows_sh ? rows_sh : 1;
		yaw = 32'(((i << 32) + (nx >> 1)) / nx);
		jp = ((j << 31) + (ny >> 1)) / ny;
		pitch = 32'(64'd0 - ONE_Q30 - jp);
		sin_cos(yaw, ys, ysn, yc, ycn);
		sin_cos(pitch, ps, psn, pc, pcn);
		v = '0;
		v.pos_x = coord(pc * yc, 60 - COORD_FRAC_BITS, pcn != ycn);
		v.pos_y = coord(pc * ys, 60 - COORD_FRAC_BITS, pcn != ysn);
		v.pos_z = coord(ps, 30 - COORD_FRAC_BITS, psn);
		v.tex_u = tex(i, nx);
		v.tex_v = tex(j, ny);
		if (i < nx && j < ny) begin
			a = i * (ny + 1) + j;
			b = (i + 1) * (ny + 1) + j;
			v.tri_index0 = a[IDX_W-1:0];
			v.tri_index1 = b[IDX_W-1:0];
			v.tri_index2 = 21'(a + 1);
			v.tri_index3 = 21'(a + 1);
			v.tri_index4 = b[IDX_W-1:0];
			v.tri_index5 = 21'(b + 1);
			v.has_quad = 1'b1;
		end
		return v;
	endfunction

	// ---------------- checking ----------------
	task automatic report(input string what, input longint got, input longint want);
		errors++;
		$display("[%0t] mismatch %s: got %0d, expected %0d", $time, what, got, want);
	endtask

	function automatic void unpack_fields(input out_t v, output longint f[12]);
		f = '{v.pos_x, v.pos_y, v.pos_z, v.tex_u, v.tex_v, v.tri_index0, v.tri_index1,
			v.tri_index2, v.tri_index3, v.tri_index4, v.tri_index5, v.has_quad};
	endfunction

	always @(posedge clk) begin
		longint got[12];
		longint want[12];
		string names[12];
		out_t wv;
		names = '{"pos_x", "pos_y", "pos_z", "tex_u", "tex_v", "tri_index0", "tri_index1",
			"tri_index2", "tri_index3", "tri_index4", "tri_index5", "has_quad"};
		if (arst_n && result_valid && result_ready) begin
			if (vertex_q.size() == 0) begin
				report("unexpected beat", 1, 0);
			end else begin
				wv = vertex_q.pop_front();
				unpack_fields(result, got);
				unpack_fields(wv, want);
				for (int k = 0; k < 12; k++)
					if (got[k] !== want[k]) report(names[k], got[k], want[k]);
			end
		end
	end

	// ---------------- output side ----------------
	always @(negedge clk) begin
		int stall;
		int hold;
		if (hold_req && hold == 0) hold = HOLD_CYCLES;
		if (hold > 0) begin
			hold--;
			if (hold == 0) hold_req = 0;
			result_ready = 1'b0;
		end else if (stall > 0) begin
			stall--;
			result_ready = 1'b0;
		end else if (!quiet && $urandom_range(0, 11) == 0) begin
			stall = $urandom_range(1, 18) - 1;
			result_ready = 1'b0;
		end else begin
			result_ready = arst_n;
		end
	end

	// ---------------- input side ----------------
	task automatic send_point(input in_t p, input bit typed = 0, input out_t tv = '0);
		if (!quiet && $urandom_range(0, 9) == 0) begin
			item_valid = 1'b0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
		item = p;
		item_valid = 1'b1;
		do @(posedge clk); while (!item_ready);
		vertex_q = {vertex_q, (typed ? tv : vertex_of(p))};
		@(negedge clk);
		item_valid = 1'b0;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SEG_W-1:0] val);
		cfg_index = idx;
		cfg_data = val;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_X_SEGMENTS) cols_sh = val;
		else if (idx == CFG_Y_SEGMENTS) rows_sh = val;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic drain();
		while (vertex_q.size() != 0) @(negedge clk);
		repeat (PIPE_LAT + 3) @(negedge clk);
	endtask

	function automatic logic [SEG_W-1:0] pick(input logic [SEG_W-1:0] n);
		int hi;
		hi = (n == 0) ? 2 : n + 1;
		if (hi > 2047) hi = 2047;
		case ($urandom_range(0, 9))
			0: return SEG_W'($urandom_range(0, 2047));
			1: return SEG_W'(hi);
			2: return '0;
			default: return SEG_W'($urandom_range(0, hi));
		endcase
	endfunction

	typedef struct {
		logic [SEG_W-1:0] column;
		logic [SEG_W-1:0] row;
		bit typed;
		out_t want;
	} point_row_t;

	point_row_t points[] = '{
		'{0, 0, 1, '{0, 0, -16'sd32768, 0, 0, 0, 17, 1, 1, 17, 18, 1}},
		'{32, 16, 1, '{0, 0, 16'sd32767, 65536, 65536, 0, 0, 0, 0, 0, 0, 0}},
		'{31, 15, 0, '0}, '{32, 0, 0, '0}, '{0, 16, 0, '0}, '{16, 8, 0, '0},
		'{8, 4, 0, '0}, '{24, 12, 0, '0}, '{33, 17, 0, '0}, '{2047, 2047, 0, '0},
		'{2047, 0, 0, '0}, '{0, 2047, 0, '0}, '{1024, 1024, 0, '0}, '{1365, 682, 0, '0},
		'{4, 2, 0, '0}, '{12, 6, 0, '0}, '{31, 0, 0, '0}, '{0, 15, 0, '0}
	};

	logic [SEG_W-1:0] settings[9][2] = '{
		'{32, 16}, '{1, 1}, '{1024, 1024}, '{0, 0}, '{2047, 2047},
		'{7, 5}, '{3, 1024}, '{1024, 2}, '{32, 16}
	};

	initial begin
		in_t p;
		cols_sh = 11'd32;
		rows_sh = 11'd16;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (points[n]) begin
			p.column = points[n].column;
			p.row = points[n].row;
			send_point(p, points[n].typed, points[n].want);
		end
		drain();
		// write to an unused index must leave both counts alone
		write_reg(CFG_UNUSED_INDEX, 11'd3);
		send_point('{5, 3});

		for (int s = 1; s < 9; s++) begin
			drain();
			quiet = (s == 8);
			write_reg(CFG_X_SEGMENTS, settings[s][0]);
			write_reg(CFG_Y_SEGMENTS, settings[s][1]);
			if (s == 5) hold_req = 1;  // long hold-off while inputs keep coming
			for (int n = 0; n < 65; n++) begin
				p.column = pick(cols_sh);
				p.row = pick(rows_sh);
				send_point(p);
				if (s == 3 && n == 30) drain();
			end
		end
		drain();
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
